FILE: src/lnit_pkg.sv
// Shared types and codes for the line number index table.
`default_nettype none
package lnit_pkg;

  // Operation codes carried by each input word.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_FIND  = 2'd2,
    OP_NEXT  = 2'd3
  } op_t;

  localparam int LINE_W = 16;
  localparam int POS_W  = 16;

  // Query token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic                     vld;
    op_t                      op;
    logic signed [LINE_W-1:0] line;
    logic        [POS_W-1:0]  pos;
    logic                     hit;
    logic signed [LINE_W-1:0] best_line;
    logic        [POS_W-1:0]  best_pos;
  } tok_t;

  // Append request broadcast to the cells; the cell at the fill count takes it.
  typedef struct packed {
    logic                     we;
    logic signed [LINE_W-1:0] line;
    logic        [POS_W-1:0]  pos;
  } app_t;

endpackage
`default_nettype wire

FILE: src/lnit_cell.sv
// One table cell: holds one entry and processes the passing query token.
`default_nettype none
module lnit_cell
  import lnit_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IDX   = 0,
  parameter int CW    = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tok_t          tok_i,
  output tok_t               tok_o,
  input  wire logic [CW-1:0] count,
  input  wire app_t          app
);

  logic signed [LINE_W-1:0] line_r;
  logic        [POS_W-1:0]  pos_r;
  tok_t                     tok_r;
  tok_t                     tok_nxt;
  logic                     active;
  logic                     match;
  logic                     upd;

  assign active = (CW'(IDX) < count) && (IDX < DEPTH);
  assign match  = active && (line_r == tok_i.line);
  assign upd    = tok_i.vld && (tok_i.op == OP_ADD) && match;

  // Token update: record a hit (with the stored position for a find) or a better successor.
  always_comb begin
    tok_nxt = tok_i;
    case (tok_i.op)
      OP_ADD: begin
        if (match) tok_nxt.hit = 1'b1;
      end
      OP_FIND: begin
        if (match) begin
          tok_nxt.hit      = 1'b1;
          tok_nxt.best_pos = pos_r;
        end
      end
      OP_NEXT: begin
        if (active && (line_r > tok_i.line) &&
            (!tok_i.hit || (line_r < tok_i.best_line))) begin
          tok_nxt.hit       = 1'b1;
          tok_nxt.best_line = line_r;
          tok_nxt.best_pos  = pos_r;
        end
      end
      default: ;
    endcase
  end

  // Token register; only its valid bit needs reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // Entry storage: written on append, position rewritten on update.
  always_ff @(posedge clk) begin
    if (app.we && (count == CW'(IDX))) begin
      line_r <= app.line;
      pos_r  <= app.pos;
    end else if (upd) begin
      pos_r <= tok_i.pos;
    end
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

FILE: src/line_number_index_table.sv
// Line number index table: a chain of entry cells walked by each query word.
// Each accepted word sends a query token through every cell register in turn; the
// sequencer takes the token from the chain end in ST_SCAN and writes the output word
// register in ST_FIN. A new word is taken only once the sequencer is back in ST_IDLE,
// and a result held by the receiver stalls the sequencer in ST_FIN.
// Reset: the fill count clears to zero; entry storage holds no reset value.
`default_nettype none
module line_number_index_table
  import lnit_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // operation[1:0], line_number[17:2], text_position[33:18]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata   // found[0], result_line[16:1], result_position[32:17]
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t                   state_r;
  logic [CW-1:0]            count_r;
  tok_t                     res_r;
  tok_t                     tok [0:TABLE_DEPTH];
  app_t                     app;
  logic                     in_acc;
  logic                     fin_go;
  logic                     room;
  logic                     out_found_r;
  logic signed [LINE_W-1:0] out_line_r;
  logic        [POS_W-1:0]  out_pos_r;
  logic                     out_vld_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign fin_go    = (state_r == ST_FIN) && (!out_vld_r || out_tready);
  assign room      = (count_r < CW'(TABLE_DEPTH));

  // Token injected into the first cell.
  always_comb begin
    tok[0].vld       = in_acc;
    tok[0].op        = op_t'(in_tdata[1:0]);
    tok[0].line      = in_tdata[17:2];
    tok[0].pos       = in_tdata[33:18];
    tok[0].hit       = 1'b0;
    tok[0].best_line = '0;
    tok[0].best_pos  = '0;
  end

  // Append of a new line after a missed add, while the table has room.
  always_comb begin
    app.we   = fin_go && (res_r.op == OP_ADD) && !res_r.hit && room;
    app.line = res_r.line;
    app.pos  = res_r.pos;
  end

  // Cell chain.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    lnit_cell #(
      .DEPTH (TABLE_DEPTH),
      .IDX   (g),
      .CW    (CW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok[g]),
      .tok_o (tok[g+1]),
      .count (count_r),
      .app   (app)
    );
  end

  // Sequencer, fill count and output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && out_tready && !fin_go) out_vld_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (tok[TABLE_DEPTH].vld) begin
            res_r   <= tok[TABLE_DEPTH];
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            out_vld_r   <= 1'b1;
            out_found_r <= 1'b0;
            out_line_r  <= '0;
            out_pos_r   <= '0;
            case (res_r.op)
              OP_CLEAR: begin
                count_r     <= '0;
                out_found_r <= 1'b1;
              end
              OP_ADD: begin
                if (res_r.hit) begin
                  out_found_r <= 1'b1;
                end else if (room) begin
                  count_r     <= count_r + CW'(1);
                  out_found_r <= 1'b1;
                end
              end
              OP_FIND: begin
                if (res_r.hit) begin
                  out_found_r <= 1'b1;
                  out_line_r  <= res_r.line;
                  out_pos_r   <= res_r.best_pos;
                end
              end
              default: begin
                if (res_r.hit) begin
                  out_found_r <= 1'b1;
                  out_line_r  <= res_r.best_line;
                  out_pos_r   <= res_r.best_pos;
                end
              end
            endcase
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_pos_r, out_line_r, out_found_r};

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("fill count exceeds table depth");

  // A token leaves the chain only while a scan is in progress.
  a_tok_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tok[TABLE_DEPTH].vld |-> (state_r == ST_SCAN))
    else $error("token left chain outside a scan");

  // An accepted word always starts a scan.
  a_acc_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN))
    else $error("accepted word did not start a scan");

  // A fresh result appears only when the sequencer finishes.
  a_out_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(state_r) == ST_FIN))
    else $error("result word without finished scan");

endmodule
`default_nettype wire

FILE: tb/sv/line_number_index_table_tb.sv
// Self-checking testbench for the line number index table, with a scoreboard and stream drivers.
module line_number_index_table_tb
  import lnit_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH   = 64;
  localparam int RANDOM_WORDS  = 450;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 2 * (TABLE_DEPTH + 3);

  // One lookup result: found flag, line and position.
  typedef struct packed {
    logic                     found;
    logic signed [LINE_W-1:0] line;
    logic        [POS_W-1:0]  pos;
  } lookup_t;

  // Keeps its own copy of the table and the results still owed by the block.
  class line_index_checker #(int DEPTH = 64);
    logic signed [LINE_W-1:0] stored_line [DEPTH];
    logic        [POS_W-1:0]  stored_pos  [DEPTH];
    int unsigned              fill;
    lookup_t                  owed_results [$];
    int                       errors;
    int                       checked;
    int                       op_count [4];
    int                       hits;
    int                       updates;
    int                       drops;
    int unsigned              max_fill;

    function new();
      fill = 0;
      errors = 0;
      checked = 0;
      hits = 0;
      updates = 0;
      drops = 0;
      max_fill = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Works out the result of one accepted input word and queues it.
    function void note_word(logic [39:0] w);
      op_t                      op;
      logic signed [LINE_W-1:0] line;
      logic        [POS_W-1:0]  pos;
      lookup_t                  r;
      int                       idx;
      bit                       any;
      op = op_t'(w[1:0]);
      line = w[17:2];
      pos = w[33:18];
      r = '0;
      idx = -1;
      any = 0;
      op_count[op]++;
      case (op)
        OP_CLEAR: begin
          fill = 0;
          r.found = 1'b1;
        end
        OP_ADD: begin
          for (int i = int'(fill) - 1; i >= 0 && idx < 0; i--)
            if (stored_line[i] == line) idx = i;
          if (idx >= 0) begin
            stored_pos[idx] = pos;
            r.found = 1'b1;
            updates++;
          end else if (fill < DEPTH) begin
            stored_line[fill] = line;
            stored_pos[fill] = pos;
            fill++;
            r.found = 1'b1;
            if (fill > max_fill) max_fill = fill;
          end else begin
            drops++;
          end
        end
        OP_FIND: begin
          for (int i = int'(fill) - 1; i >= 0 && idx < 0; i--)
            if (stored_line[i] == line) idx = i;
          if (idx >= 0) begin
            r.found = 1'b1;
            r.line = line;
            r.pos = stored_pos[idx];
          end
        end
        default: begin
          // Smallest stored line strictly above the query; signed compare.
          for (int i = int'(fill) - 1; i >= 0; i--) begin
            if (stored_line[i] > line && (!any || stored_line[i] < r.line)) begin
              any = 1;
              r.line = stored_line[i];
              r.pos = stored_pos[i];
            end
          end
          r.found = any;
        end
      endcase
      if ((op == OP_FIND || op == OP_NEXT) && r.found) hits++;
      owed_results.push_back(r);
    endfunction

    // Compares one accepted result word with the oldest owed result.
    function void check_result(logic [39:0] d);
      lookup_t want;
      lookup_t got;
      got.found = d[0];
      got.line = d[16:1];
      got.pos = d[32:17];
      if (owed_results.size() == 0) begin
        $display("%0t: result word with nothing owed: found %0b line %0d pos %0h",
                 $realtime, got.found, got.line, got.pos);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      checked++;
      if (got.found !== want.found) begin
        $display("%0t: found mismatch: expected %0b, actual %0b",
                 $realtime, want.found, got.found);
        errors++;
      end
      if (got.line !== want.line) begin
        $display("%0t: result_line mismatch: expected %0d, actual %0d",
                 $realtime, want.line, got.line);
        errors++;
      end
      if (got.pos !== want.pos) begin
        $display("%0t: result_position mismatch: expected %0h, actual %0h",
                 $realtime, want.pos, got.pos);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // operation[1:0], line_number[17:2], text_position[33:18]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // found[0], result_line[16:1], result_position[32:17]

  line_index_checker #(TABLE_DEPTH) sb;

  bit steady;
  bit stall_request;
  int words_sent;
  int idle_cycles;

  line_number_index_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitor both channels at the rising edge and feed the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_word(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Watchdog: give up when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results still owed",
                 $realtime, IDLE_LIMIT, sb.pending());
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 11);
      end
    end
  end

  // Offers one word, with random gaps before it, and waits until it is taken.
  task automatic send_word(input op_t op, input logic signed [LINE_W-1:0] line,
                           input logic [POS_W-1:0] pos);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 11) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, pos, line, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // Stops offering words until every owed result has come back.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [POS_W-1:0] any_pos();
    return POS_W'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic signed [LINE_W-1:0] any_line();
    return LINE_W'($urandom_range(16'hFFFF));
  endfunction

  // Main stimulus.
  initial begin
    logic signed [LINE_W-1:0] ln;
    logic signed [LINE_W-1:0] recent [$];
    int                       base;
    int                       n;
    int                       kind;
    bit                       fill_done;
    bit                       stall_done;
    bit                       drain_done;

    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    steady = 0;
    stall_request = 0;
    words_sent = 0;
    idle_cycles = 0;
    fill_done = 0;
    stall_done = 0;
    drain_done = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extreme lines, update, successor edges, clear.
    send_word(OP_FIND, 16'sd0, 16'h0000);
    send_word(OP_NEXT, -16'sd32768, 16'hFFFF);
    send_word(OP_ADD, 16'sd100, 16'h0000);
    send_word(OP_ADD, -16'sd32768, 16'hFFFF);
    send_word(OP_ADD, 16'sd32767, 16'h1234);
    send_word(OP_ADD, 16'sd0, 16'hA5A5);
    send_word(OP_ADD, 16'sd100, 16'h5A5A);
    send_word(OP_FIND, 16'sd100, 16'h0000);
    send_word(OP_FIND, -16'sd32768, 16'h0000);
    send_word(OP_FIND, 16'sd32767, 16'h0000);
    send_word(OP_FIND, 16'sd99, 16'h0000);
    send_word(OP_NEXT, -16'sd32768, 16'h0000);
    send_word(OP_NEXT, 16'sd0, 16'h0000);
    send_word(OP_NEXT, 16'sd100, 16'h0000);
    send_word(OP_NEXT, 16'sd32767, 16'h0000);
    send_word(OP_NEXT, -16'sd1, 16'h0000);
    send_word(OP_CLEAR, 16'sd100, 16'hFFFF);
    send_word(OP_FIND, 16'sd100, 16'h0000);
    send_word(OP_NEXT, -16'sd32768, 16'h0000);
    send_word(OP_ADD, -16'sd1, 16'h8000);
    send_word(OP_FIND, -16'sd1, 16'h0000);
    send_word(OP_NEXT, -16'sd2, 16'h0000);
    drain();

    // Random part, built from short sequences.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      // Long hold-off on the result side while words keep coming.
      if (!stall_done && words_sent >= 120) begin
        stall_done = 1;
        stall_request = 1;
      end
      steady = (words_sent >= 200 && words_sent < 280);
      if (!drain_done && words_sent >= 330) begin
        drain_done = 1;
        drain();
      end

      kind = $urandom_range(99);
      if (!fill_done || kind < 5) begin
        // Fill the table past its depth, then probe it.
        fill_done = 1;
        base = $urandom_range(65535 - 3 * 80) - 32768;
        send_word(OP_CLEAR, any_line(), any_pos());
        recent.delete();
        n = TABLE_DEPTH + $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          ln = LINE_W'(base + 3 * i);
          send_word(OP_ADD, ln, any_pos());
          if (i < TABLE_DEPTH) recent.push_back(ln);
        end
        // Update of a present line into the full table.
        send_word(OP_ADD, LINE_W'(base + 3 * $urandom_range(TABLE_DEPTH - 1)), any_pos());
        send_word(OP_FIND, LINE_W'(base + 3 * (n - 1)), any_pos());
        send_word(OP_NEXT, LINE_W'(base + 3 * $urandom_range(TABLE_DEPTH - 1) + 1),
                  any_pos());
        send_word(OP_NEXT, LINE_W'(base - 1), any_pos());
        send_word(OP_NEXT, LINE_W'(base + 3 * (TABLE_DEPTH - 1)), any_pos());
      end else if (kind < 85) begin
        // Well-formed: maybe clear, a few adds, then lookups near stored lines.
        if ($urandom_range(1)) begin
          send_word(OP_CLEAR, any_line(), any_pos());
          recent.delete();
        end
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
          ln = $urandom_range(1) ? LINE_W'($urandom_range(40) - 20) : any_line();
          send_word(OP_ADD, ln, any_pos());
          recent.push_back(ln);
        end
        n = $urandom_range(2, 10);
        for (int i = 0; i < n; i++) begin
          ln = (recent.size() > 0) ? recent[$urandom_range(recent.size() - 1)] : any_line();
          case ($urandom_range(3))
            0: ln = ln + 16'sd1;
            1: ln = ln - 16'sd1;
            2: ln = any_line();
            default: ;
          endcase
          send_word($urandom_range(1) ? OP_FIND : OP_NEXT, ln, any_pos());
        end
      end else begin
        // Noise: any operation with any fields.
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
          send_word(op_t'($urandom_range(3)), any_line(), any_pos());
      end
    end
    steady = 0;

    // Wait for the last results, then watch for stray words.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d clears, %0d adds (%0d updates, %0d dropped), %0d finds,",
             sb.checked, sb.op_count[OP_CLEAR], sb.op_count[OP_ADD], sb.updates, sb.drops,
             sb.op_count[OP_FIND]);
    $display("%0d successor searches, %0d lookup hits, table filled up to %0d entries.",
             sb.op_count[OP_NEXT], sb.hits, sb.max_fill);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
